@@ rtl/srg_pkg.sv @@
// ---------------------------------------------------------------------------
// srg_pkg
// Shared widths, fixed-point helpers and sequencer states for the Schur
// reflection generator.
// ---------------------------------------------------------------------------
`default_nettype none
package srg_pkg;

    localparam int MAX_LEN    = 64;
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 24;

    localparam int IDX_W  = $clog2(MAX_LEN);
    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int BANK_W = IDX_W + 1;
    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int QUO_W  = DATA_WIDTH + FRAC_BITS;
    localparam int DIV_CW = $clog2(QUO_W);
    localparam int MAG_W  = PROD_W + FRAC_BITS;

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic [DATA_WIDTH-1:0]        t_umag;
    typedef logic [MAG_W-1:0]             t_wide;

    localparam t_data VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam t_data VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam t_data Q_ONE = (FRAC_BITS < DATA_WIDTH - 1) ?
                              t_data'(64'sd1 <<< FRAC_BITS) : VMAX;

    typedef enum logic [4:0] {
        S_LOAD, S_K_RD, S_K_LD,
        S_J_RD, S_J_M1, S_J_M2, S_J_M3, S_J_M4,
        S_DIV_INIT, S_DIV_RUN, S_G_WR,
        S_P1, S_P2, S_P3, S_P4,
        S_X_RD1, S_X_RD2, S_X_M1, S_X_M2, S_X_M3, S_X_M4,
        S_K_NEXT, S_OUT_RD, S_OUT_CAP, S_OUT_WAIT
    } t_state;

    function automatic t_data sat_add(input t_data a, input t_data b);
        logic signed [DATA_WIDTH:0] s;
        s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
            return s[DATA_WIDTH] ? VMIN : VMAX;
        end
        return t_data'(s[DATA_WIDTH-1:0]);
    endfunction

    function automatic t_data sat_sub(input t_data a, input t_data b);
        logic signed [DATA_WIDTH:0] s;
        s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
            return s[DATA_WIDTH] ? VMIN : VMAX;
        end
        return t_data'(s[DATA_WIDTH-1:0]);
    endfunction

    function automatic t_umag mag(input t_data x);
        return x[DATA_WIDTH-1] ? t_umag'(~x + 1'b1) : t_umag'(x);
    endfunction

    // Apply sign to a magnitude, clamping to the signed range.
    function automatic t_data sat_mag(input logic neg, input t_wide m);
        t_wide lim;
        lim = neg ? (t_wide'(1) << (DATA_WIDTH - 1)) : t_wide'(VMAX);
        if (m > lim) begin
            return neg ? VMIN : VMAX;
        end
        return neg ? t_data'(~m[DATA_WIDTH-1:0] + 1'b1) : t_data'(m[DATA_WIDTH-1:0]);
    endfunction

endpackage
`default_nettype wire

@@ rtl/srg_in_if.sv @@
// ---------------------------------------------------------------------------
// srg_in_if
// Request channel carrying one generator pair.
// ---------------------------------------------------------------------------
`default_nettype none
interface srg_in_if;
    logic          valid;
    logic          ready;
    srg_pkg::t_data alpha_sample;
    srg_pkg::t_data beta_sample;
    logic          is_last;

    modport source(output valid, output alpha_sample, output beta_sample,
                   output is_last, input ready);
    modport sink(input valid, input alpha_sample, input beta_sample,
                 input is_last, output ready);
endinterface
`default_nettype wire

@@ rtl/srg_out_if.sv @@
// ---------------------------------------------------------------------------
// srg_out_if
// Result channel carrying one coefficient set per index.
// ---------------------------------------------------------------------------
`default_nettype none
interface srg_out_if;
    logic                         valid;
    logic                         ready;
    logic [srg_pkg::IDX_W-1:0]    coef_index;
    srg_pkg::t_data               reflection;
    srg_pkg::t_data               xi_coef;
    srg_pkg::t_data               eta_coef;
    logic                         pivot_error;
    logic                         run_end;

    modport source(output valid, output coef_index, output reflection,
                   output xi_coef, output eta_coef, output pivot_error,
                   output run_end, input ready);
    modport sink(input valid, input coef_index, input reflection,
                 input xi_coef, input eta_coef, input pivot_error,
                 input run_end, output ready);
endinterface
`default_nettype wire

@@ rtl/schur_reflection_generator_top.sv @@
// ---------------------------------------------------------------------------
// schur_reflection_generator_top
// Progressive Schur recursion over a loaded run of generator pairs.
// ---------------------------------------------------------------------------
// Generator pairs load at one request per cycle while in the load state;
// the pair marked is_last closes the run (pairs beyond 64 are dropped). The
// recursion then runs on one shared pipelined multiplier and synchronous
// memories with separate read and write addresses: inner beta steps, xi/eta
// steps, and per index the 56-step bit-serial divider (skipped on a zero
// pivot) and the pivot update. The n results then leave one at a time, each
// held until taken, and loading of the next run may start once the last
// result is taken.
// A zero pivot saturates gamma and flags pivot_error on every result of that
// run.
`default_nettype none
module schur_reflection_generator_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    srg_in_if.sink    i_req,
    srg_out_if.source o_rsp
);

    localparam int IW = srg_pkg::IDX_W;
    localparam int BW = srg_pkg::BANK_W;

    srg_pkg::t_state r_state, n_state;

    logic [srg_pkg::CNT_W-1:0]  r_cnt, r_n;
    logic [IW-1:0]              r_k, r_j, r_idx;
    logic                       r_cur, r_err;
    srg_pkg::t_data             r_t, r_bw0, r_g, r_g0, r_gj, r_bwj;
    srg_pkg::t_data             r_xj, r_ej, r_xkj, r_xnew;
    srg_pkg::t_data             r_ma, r_mb;
    logic [srg_pkg::PROD_W-1:0] r_prod;
    logic                       r_pneg;
    logic [srg_pkg::QUO_W-1:0]  r_dq;
    srg_pkg::t_umag             r_rem, r_d;
    logic [srg_pkg::DIV_CW-1:0] r_dcnt;
    logic                       r_dneg, r_zero;

    // output register
    logic                       r_ovalid, r_oend, r_oerr;
    logic [IW-1:0]              r_oidx;
    srg_pkg::t_data             r_orefl, r_oxi, r_oeta;

    // memories
    srg_pkg::t_data alpha_mem [srg_pkg::MAX_LEN];
    srg_pkg::t_data beta_mem  [srg_pkg::MAX_LEN];
    srg_pkg::t_data gamma_mem [srg_pkg::MAX_LEN];
    srg_pkg::t_data xi_mem    [2 * srg_pkg::MAX_LEN];
    srg_pkg::t_data eta_mem   [2 * srg_pkg::MAX_LEN];

    srg_pkg::t_data alpha_rd, beta_rd, gamma_rd, xi_rd, eta_rd;

    logic           alpha_we, beta_we, gamma_we, xe_we;
    logic [IW-1:0]  alpha_addr, beta_waddr, beta_raddr, gamma_raddr;
    srg_pkg::t_data beta_wdata, gamma_wdata, xi_wdata, eta_wdata;
    logic [BW-1:0]  xe_raddr, xe_waddr;

    logic           in_fire, out_fire, j_last, k_last, o_last, div_done;
    srg_pkg::t_data qres, g_val;
    logic [srg_pkg::DATA_WIDTH:0] rem_s;
    logic           rem_ge;

    assign in_fire  = i_req.valid && i_req.ready;
    assign out_fire = o_rsp.valid && o_rsp.ready;
    assign j_last   = (r_j == r_k);
    assign k_last   = ({1'b0, r_k} + 1'b1) == r_n;
    assign o_last   = ({1'b0, r_idx} + 1'b1) == r_n;
    assign div_done = (r_dcnt == srg_pkg::DIV_CW'(srg_pkg::QUO_W - 1));

    assign qres  = srg_pkg::sat_mag(r_pneg, srg_pkg::t_wide'(r_prod >> srg_pkg::FRAC_BITS));
    assign g_val = r_zero ? (r_dneg ? srg_pkg::VMIN : srg_pkg::VMAX)
                          : srg_pkg::sat_mag(r_dneg, srg_pkg::t_wide'(r_dq));

    assign rem_s  = {r_rem, r_dq[srg_pkg::QUO_W-1]};
    assign rem_ge = rem_s >= {1'b0, r_d};

    assign i_req.ready       = (r_state == srg_pkg::S_LOAD);
    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.coef_index  = r_oidx;
    assign o_rsp.reflection  = r_orefl;
    assign o_rsp.xi_coef     = r_oxi;
    assign o_rsp.eta_coef    = r_oeta;
    assign o_rsp.pivot_error = r_oerr;
    assign o_rsp.run_end     = r_oend;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srg_pkg::S_LOAD:     if (in_fire && i_req.is_last) n_state = srg_pkg::S_K_RD;
            srg_pkg::S_K_RD:     n_state = srg_pkg::S_K_LD;
            srg_pkg::S_K_LD:     n_state = (r_k == '0) ? srg_pkg::S_DIV_INIT : srg_pkg::S_J_RD;
            srg_pkg::S_J_RD:     n_state = srg_pkg::S_J_M1;
            srg_pkg::S_J_M1:     n_state = srg_pkg::S_J_M2;
            srg_pkg::S_J_M2:     n_state = srg_pkg::S_J_M3;
            srg_pkg::S_J_M3:     n_state = srg_pkg::S_J_M4;
            srg_pkg::S_J_M4:     n_state = j_last ? srg_pkg::S_DIV_INIT : srg_pkg::S_J_RD;
            srg_pkg::S_DIV_INIT: n_state = (r_bw0 == '0) ? srg_pkg::S_G_WR : srg_pkg::S_DIV_RUN;
            srg_pkg::S_DIV_RUN:  if (div_done) n_state = srg_pkg::S_G_WR;
            srg_pkg::S_G_WR:     n_state = srg_pkg::S_P1;
            srg_pkg::S_P1:       n_state = srg_pkg::S_P2;
            srg_pkg::S_P2:       n_state = srg_pkg::S_P3;
            srg_pkg::S_P3:       n_state = srg_pkg::S_P4;
            srg_pkg::S_P4:       n_state = (r_k == '0) ? srg_pkg::S_K_NEXT : srg_pkg::S_X_RD1;
            srg_pkg::S_X_RD1:    n_state = srg_pkg::S_X_RD2;
            srg_pkg::S_X_RD2:    n_state = srg_pkg::S_X_M1;
            srg_pkg::S_X_M1:     n_state = srg_pkg::S_X_M2;
            srg_pkg::S_X_M2:     n_state = srg_pkg::S_X_M3;
            srg_pkg::S_X_M3:     n_state = srg_pkg::S_X_M4;
            srg_pkg::S_X_M4:     n_state = j_last ? srg_pkg::S_K_NEXT : srg_pkg::S_X_RD1;
            srg_pkg::S_K_NEXT:   n_state = k_last ? srg_pkg::S_OUT_RD : srg_pkg::S_K_RD;
            srg_pkg::S_OUT_RD:   n_state = srg_pkg::S_OUT_CAP;
            srg_pkg::S_OUT_CAP:  n_state = srg_pkg::S_OUT_WAIT;
            srg_pkg::S_OUT_WAIT: if (out_fire) n_state = o_last ? srg_pkg::S_LOAD : srg_pkg::S_OUT_RD;
            default:             n_state = srg_pkg::S_LOAD;
        endcase
    end

    // memory controls
    always_comb begin
        alpha_we    = 1'b0;
        beta_we     = 1'b0;
        gamma_we    = 1'b0;
        xe_we       = 1'b0;
        alpha_addr  = r_k;
        beta_waddr  = IW'(r_k - r_j + 1'b1);
        beta_raddr  = IW'(r_k - r_j + 1'b1);
        beta_wdata  = srg_pkg::sat_sub(r_bwj, qres);
        gamma_raddr = IW'(r_j - 1'b1);
        gamma_wdata = g_val;
        xe_raddr    = {r_cur, r_j};
        xe_waddr    = {~r_cur, r_j};
        xi_wdata    = r_xnew;
        eta_wdata   = srg_pkg::sat_add(r_ej, qres);
        unique case (r_state)
            srg_pkg::S_LOAD: begin
                alpha_we   = in_fire && (r_cnt < srg_pkg::CNT_W'(srg_pkg::MAX_LEN));
                beta_we    = alpha_we;
                alpha_addr = r_cnt[IW-1:0];
                beta_waddr = r_cnt[IW-1:0];
                beta_wdata = i_req.beta_sample;
            end
            srg_pkg::S_K_RD:   beta_raddr = r_k;
            srg_pkg::S_J_M4:   beta_we = 1'b1;
            srg_pkg::S_G_WR:   gamma_we = 1'b1;
            srg_pkg::S_P4: begin
                xe_we     = 1'b1;
                xe_waddr  = {~r_cur, {IW{1'b0}}};
                xi_wdata  = (r_k == '0) ? g_val : r_g0;
                eta_wdata = srg_pkg::Q_ONE;
            end
            srg_pkg::S_X_RD2:  xe_raddr = {r_cur, IW'(r_k - r_j)};
            srg_pkg::S_X_M4:   xe_we = 1'b1;
            srg_pkg::S_OUT_RD: begin
                gamma_raddr = r_idx;
                xe_raddr    = {r_cur, r_idx};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (alpha_we) alpha_mem[alpha_addr] <= i_req.alpha_sample;
        if (beta_we)  beta_mem[beta_waddr] <= beta_wdata;
        if (gamma_we) gamma_mem[r_k] <= gamma_wdata;
        if (xe_we) begin
            xi_mem[xe_waddr]  <= xi_wdata;
            eta_mem[xe_waddr] <= eta_wdata;
        end
        alpha_rd <= alpha_mem[alpha_addr];
        beta_rd  <= beta_mem[beta_raddr];
        gamma_rd <= gamma_mem[gamma_raddr];
        xi_rd    <= xi_mem[xe_raddr];
        eta_rd   <= eta_mem[xe_raddr];
    end

    // shared multiplier: operands, then magnitude product
    always_ff @(posedge i_clk) begin
        r_prod <= srg_pkg::PROD_W'(srg_pkg::mag(r_ma)) * srg_pkg::PROD_W'(srg_pkg::mag(r_mb));
        r_pneg <= r_ma[srg_pkg::DATA_WIDTH-1] ^ r_mb[srg_pkg::DATA_WIDTH-1];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= srg_pkg::S_LOAD;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == srg_pkg::S_LOAD && in_fire) begin
                if (i_req.is_last) begin
                    r_cnt <= '0;
                end else if (r_cnt < srg_pkg::CNT_W'(srg_pkg::MAX_LEN)) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (r_state == srg_pkg::S_OUT_CAP) r_ovalid <= 1'b1;
            else if (out_fire) r_ovalid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            srg_pkg::S_LOAD: begin
                if (in_fire && i_req.is_last) begin
                    r_n   <= (r_cnt < srg_pkg::CNT_W'(srg_pkg::MAX_LEN)) ? r_cnt + 1'b1 : r_cnt;
                    r_k   <= '0;
                    r_cur <= 1'b1;
                    r_err <= 1'b0;
                end
            end
            srg_pkg::S_K_LD: begin
                r_t <= alpha_rd;
                if (r_k == '0) r_bw0 <= beta_rd;
                r_j <= IW'(1);
            end
            srg_pkg::S_J_M1: begin
                r_gj  <= gamma_rd;
                r_bwj <= beta_rd;
                r_ma  <= gamma_rd;
                r_mb  <= beta_rd;
            end
            srg_pkg::S_J_M2: begin
                r_ma <= r_gj;
                r_mb <= r_t;
            end
            srg_pkg::S_J_M3: r_t <= srg_pkg::sat_sub(r_t, qres);
            srg_pkg::S_J_M4: r_j <= r_j + 1'b1;
            srg_pkg::S_DIV_INIT: begin
                r_zero <= (r_bw0 == '0);
                r_dneg <= (r_bw0 == '0) ? r_t[srg_pkg::DATA_WIDTH-1]
                        : (r_t[srg_pkg::DATA_WIDTH-1] ^ r_bw0[srg_pkg::DATA_WIDTH-1]);
                r_d    <= srg_pkg::mag(r_bw0);
                r_dq   <= {srg_pkg::mag(r_t), {srg_pkg::FRAC_BITS{1'b0}}};
                r_rem  <= '0;
                r_dcnt <= '0;
            end
            srg_pkg::S_DIV_RUN: begin
                // one restoring step per cycle, quotient shifts in from the right
                r_rem  <= rem_ge ? srg_pkg::t_umag'(rem_s - {1'b0, r_d})
                                 : srg_pkg::t_umag'(rem_s);
                r_dq   <= {r_dq[srg_pkg::QUO_W-2:0], rem_ge};
                r_dcnt <= r_dcnt + 1'b1;
            end
            srg_pkg::S_G_WR: begin
                r_g <= g_val;
                if (r_k == '0) r_g0 <= g_val;
                if (r_zero) r_err <= 1'b1;
                r_ma <= g_val;
                r_mb <= g_val;
            end
            srg_pkg::S_P2: begin
                r_ma <= r_bw0;
                r_mb <= srg_pkg::sat_sub(srg_pkg::Q_ONE, qres);
            end
            srg_pkg::S_P4: begin
                r_bw0 <= qres;
                r_j   <= IW'(1);
            end
            srg_pkg::S_X_RD2: begin
                // entry k of the old bank was never written this run
                r_xj <= j_last ? '0 : xi_rd;
                r_ej <= j_last ? '0 : eta_rd;
            end
            srg_pkg::S_X_M1: begin
                r_xkj <= xi_rd;
                r_ma  <= r_g;
                r_mb  <= eta_rd;
            end
            srg_pkg::S_X_M2: begin
                r_ma <= r_g;
                r_mb <= r_xkj;
            end
            srg_pkg::S_X_M3: r_xnew <= srg_pkg::sat_add(r_xj, qres);
            srg_pkg::S_X_M4: r_j <= r_j + 1'b1;
            srg_pkg::S_K_NEXT: begin
                r_cur <= ~r_cur;
                r_k   <= r_k + 1'b1;
                r_idx <= '0;
            end
            srg_pkg::S_OUT_CAP: begin
                r_oidx  <= r_idx;
                r_orefl <= gamma_rd;
                r_oxi   <= xi_rd;
                r_oeta  <= eta_rd;
                r_oerr  <= r_err;
                r_oend  <= o_last;
            end
            srg_pkg::S_OUT_WAIT: if (out_fire) r_idx <= r_idx + 1'b1;
            default: ;
        endcase
    end

endmodule
`default_nettype wire
